// ===== hdl/qphs_pkg.sv =====
`default_nettype none
package qphs_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_ACTIVE  = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic       REG_TABLE_SIZE = 1'b0;
  localparam logic       REG_OCC_LIMIT  = 1'b1;

  localparam int unsigned PROBE_SAT = 1024;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/qphs_ram.sv =====
`default_nettype none
module qphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/quadratic_probe_hash_set_top.sv =====
`default_nettype none
// Sequence: the key is hashed one byte at a time, the hash is reduced modulo the table
// size, then each probe takes a memory read and a check, and the result is retired
// once the output register is free.
// One item at a time: the next is taken the cycle after the result is retired.
// Reset: synchronous; a clearing pass then writes every slot empty, one slot a
// cycle, during which no item is taken.
module quadratic_probe_hash_set_top
  import qphs_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int KEY_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] operation, [65:2] key_bytes, [69:66] key_length, [71:70] zero
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] present, [10:1] slot_index, [12:11] status, [23:13] probe_count
  output logic      [23:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int TSW = $clog2(CAPACITY + 1);
  localparam int KW  = 8 * KEY_BYTES;
  localparam int MW  = 2 + 4 + KW;
  localparam logic [3:0] KB4 = 4'(KEY_BYTES);

  logic [10:0] cfg_size, cfg_limit, occ;
  state_t state, state_next;

  logic [1:0]     op;
  logic [KW-1:0]  key;
  logic [3:0]     len;
  logic [TSW-1:0] tsz;
  logic [31:0]    h;
  logic [KW-1:0]  hkey;
  logic [3:0]     hcnt;
  logic [4:0]     mcnt;
  logic [TSW-1:0] rem;
  logic [TSW-1:0] pos, step, probes;
  logic [AW-1:0]  clr;

  logic          res_present, res_we;
  logic [1:0]    res_status, res_mark;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  qphs_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos[AW-1:0]),
    .rdata (ram_rdata)
  );

  // input decode
  logic [3:0]     in_len;
  logic [KW-1:0]  in_key;
  logic [31:0]    size32;
  logic [TSW-1:0] in_ts;
  always_comb begin
    in_len = (s_tdata[69:66] > KB4) ? KB4 : s_tdata[69:66];
    for (int i = 0; i < KEY_BYTES; i++) begin
      in_key[8*i +: 8] = (4'(i) < in_len) ? s_tdata[2 + 8*i +: 8] : 8'd0;
    end
    size32 = {21'd0, cfg_size};
    if (size32 == 32'd0) begin
      size32 = 32'd1;
    end else if (size32 > 32'(CAPACITY)) begin
      size32 = 32'(CAPACITY);
    end
    in_ts = TSW'(size32);
  end

  // hash and modulo steps
  logic [31:0]    b32, h_next;
  logic [TSW:0]   rsh;
  logic [TSW-1:0] rem_next;
  always_comb begin
    b32 = {{24{hkey[7]}}, hkey[7:0]};
    h_next = (h << 5) ^ b32 ^ h;
    rsh = {rem, h[31]};
    rem_next = (rsh >= {1'b0, tsz}) ? TSW'(rsh - {1'b0, tsz}) : rsh[TSW-1:0];
  end

  // probe check and advance
  logic [1:0]    rd_mark;
  logic [3:0]    rd_len;
  logic [KW-1:0] rd_key;
  logic          stop, last, active;
  logic [TSW:0]  psum, ssum;
  logic [TSW-1:0] pos_adv, step_adv;
  logic [11:0]   occ_inc;
  always_comb begin
    {rd_mark, rd_len, rd_key} = ram_rdata;
    stop   = (rd_mark == MARK_EMPTY) || (rd_len == len && rd_key == key);
    last   = stop || (probes >= tsz);
    active = stop && rd_mark == MARK_ACTIVE;
    psum = {1'b0, pos} + {1'b0, step};
    pos_adv = (psum >= {1'b0, tsz}) ? TSW'(psum - {1'b0, tsz}) : psum[TSW-1:0];
    ssum = {1'b0, step} + (TSW+1)'(2);
    step_adv = (ssum >= {1'b0, tsz}) ? TSW'(ssum - {1'b0, tsz}) : ssum[TSW-1:0];
    occ_inc = {1'b0, occ} + 12'd1;
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ram_we    = 1'b0;
    ram_waddr = pos[AW-1:0];
    ram_wdata = {res_mark, len, key};
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = {MARK_EMPTY, {(MW-2){1'b0}}};
        if (clr == AW'(CAPACITY - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = (in_len == 4'd0) ? S_MOD : S_HASH;
      end
      S_HASH: begin
        if (hcnt == 4'd1) state_next = S_MOD;
      end
      S_MOD: begin
        if (mcnt == 5'd31) state_next = S_READ;
      end
      S_READ:  state_next = S_CHECK;
      S_CHECK: state_next = last ? S_FINISH : S_READ;
      S_FINISH: begin
        if (out_free) begin
          ram_we = res_we;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cfg_size  <= 11'd101;
      cfg_limit <= 11'd50;
      occ       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_TABLE_SIZE) cfg_size <= cfg_data;
        else cfg_limit <= cfg_data;
      end
      if (state == S_CLEAR) clr <= clr + AW'(1);
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
        if (res_we && op == OP_INSERT) occ <= occ_inc[10:0];
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op     <= s_tdata[1:0];
        key    <= in_key;
        hkey   <= in_key;
        len    <= in_len;
        hcnt   <= in_len;
        tsz    <= in_ts;
        h      <= '0;
        mcnt   <= '0;
        rem    <= '0;
      end
      S_HASH: begin
        h    <= h_next;
        hkey <= hkey >> 8;
        hcnt <= hcnt - 4'd1;
      end
      S_MOD: begin
        rem  <= rem_next;
        h    <= h << 1;
        mcnt <= mcnt + 5'd1;
        if (mcnt == 5'd31) begin
          pos    <= rem_next;
          step   <= TSW'(1);
          probes <= TSW'(1);
        end
      end
      S_CHECK: begin
        if (last) begin
          res_present <= active;
          res_we      <= 1'b0;
          res_mark    <= MARK_ACTIVE;
          case (op)
            OP_INSERT: begin
              if (!stop) res_status <= ST_FULL;
              else if (active) res_status <= ST_PRESENT;
              else if (occ_inc > {1'b0, cfg_limit}) res_status <= ST_FULL;
              else begin
                res_status <= ST_DONE;
                res_we     <= 1'b1;
              end
            end
            OP_REMOVE: begin
              res_mark <= MARK_DELETED;
              if (active) begin
                res_status <= ST_DONE;
                res_we     <= 1'b1;
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end
            default: res_status <= active ? ST_DONE : ST_NOT_FOUND;
          endcase
        end else begin
          pos    <= pos_adv;
          step   <= step_adv;
          probes <= probes + TSW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register: load on retire
  logic [31:0] pr32, pos32;
  always_comb begin
    pr32  = 32'(probes);
    pos32 = 32'(pos);
    if (pr32 > PROBE_SAT) pr32 = PROBE_SAT;
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      m_tdata <= {pr32[10:0], res_status, pos32[9:0], res_present};
    end
  end

endmodule
`default_nettype wire
